[hdl/bst_pkg.sv]
`timescale 1ns / 1ps

package bst_pkg;

    typedef logic [3:0] t_factor;

    localparam t_factor F_ZERO      = 4'd0;
    localparam t_factor F_ONE       = 4'd1;
    localparam t_factor F_SRCCOL    = 4'd2;
    localparam t_factor F_INVSRCCOL = 4'd3;
    localparam t_factor F_SRCA      = 4'd4;
    localparam t_factor F_INVSRCA   = 4'd5;
    localparam t_factor F_DSTA      = 4'd6;
    localparam t_factor F_INVDSTA   = 4'd7;
    localparam t_factor F_DSTCOL    = 4'd8;
    localparam t_factor F_INVDSTCOL = 4'd9;
    localparam t_factor F_SRC1A     = 4'd10;
    localparam t_factor F_INVSRC1A  = 4'd11;

    localparam logic [2:0] FMT_WITH_ALPHA = 3'd1;
    localparam logic [2:0] FMT_DEPTH_ONLY = 3'd3;

    localparam logic COMBINE_ADD    = 1'b0;
    localparam logic COMBINE_REVSUB = 1'b1;

    typedef struct packed {
        logic       blend_en;
        logic       lop_en;
        logic [7:0] logic_op_code;
        t_factor    src_color_factor;
        t_factor    dst_color_factor;
        t_factor    src_alpha_factor;
        t_factor    dst_alpha_factor;
        logic       color_combine_mode;
        logic       alpha_combine_mode;
        logic       color_write;
        logic       alpha_write;
        logic       dual_src;
    } t_desc;

    function automatic t_factor src_map(input logic [2:0] idx);
        t_factor f;
        case (idx)
            3'd0: f = F_ZERO;
            3'd1: f = F_ONE;
            3'd2: f = F_DSTCOL;
            3'd3: f = F_INVDSTCOL;
            3'd4: f = F_SRCA;
            3'd5: f = F_INVSRCA;
            3'd6: f = F_DSTA;
            3'd7: f = F_INVDSTA;
            default: f = F_ZERO;
        endcase
        return f;
    endfunction

    function automatic t_factor dst_map(input logic [2:0] idx);
        t_factor f;
        case (idx)
            3'd0: f = F_ZERO;
            3'd1: f = F_ONE;
            3'd2: f = F_SRCCOL;
            3'd3: f = F_INVSRCCOL;
            3'd4: f = F_SRCA;
            3'd5: f = F_INVSRCA;
            3'd6: f = F_DSTA;
            3'd7: f = F_INVDSTA;
            default: f = F_ZERO;
        endcase
        return f;
    endfunction

    // ROP3 codes with source as 0xCC and destination as 0xAA.
    function automatic logic [7:0] rop3_map(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = 8'h00;
            4'd1:  c = 8'h88;
            4'd2:  c = 8'h44;
            4'd3:  c = 8'hCC;
            4'd4:  c = 8'h22;
            4'd5:  c = 8'hAA;
            4'd6:  c = 8'h66;
            4'd7:  c = 8'hEE;
            4'd8:  c = 8'h11;
            4'd9:  c = 8'h99;
            4'd10: c = 8'h55;
            4'd11: c = 8'hDD;
            4'd12: c = 8'h33;
            4'd13: c = 8'hBB;
            4'd14: c = 8'h77;
            4'd15: c = 8'hFF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_factor no_alpha_fix(input t_factor f);
        t_factor r;
        if (f == F_DSTA) begin
            r = F_ONE;
        end else if (f == F_INVDSTA) begin
            r = F_ZERO;
        end else begin
            r = f;
        end
        return r;
    endfunction

    function automatic t_factor dual_fix(input t_factor f);
        t_factor r;
        if (f == F_SRCA) begin
            r = F_SRC1A;
        end else if (f == F_INVSRCA) begin
            r = F_INVSRC1A;
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage

[hdl/blend_state_translator_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_ready  i_blend_mode_word, i_efb_format,
//                                         i_dual_source_request
// result    out        o_valid / i_ready  o_blend_en ... o_dual_src_alpha
//
// One word per cycle while the result is not stalled. An accepted word is decoded
// out of the input register and lands in the result register once that register is
// empty or its result is being taken, and it is offered from there.
// Reset (synchronous, active low) empties both stages; no clearing pass.
// When the result is stalled the input stage still takes a word if it is empty,
// so up to two words are held while the output waits.

module blend_state_translator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_blend_mode_word,
    input  logic [2:0]  i_efb_format,
    input  logic        i_dual_source_request,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_blend_en,
    output logic        o_logic_op_en,
    output logic [7:0]  o_logic_op_code,
    output logic [3:0]  o_src_color_factor,
    output logic [3:0]  o_dst_color_factor,
    output logic [3:0]  o_src_alpha_factor,
    output logic [3:0]  o_dst_alpha_factor,
    output logic        o_color_combine_mode,
    output logic        o_alpha_combine_mode,
    output logic        o_color_write,
    output logic        o_alpha_write,
    output logic        o_dual_src_alpha
);
    import bst_pkg::*;

    logic        r_s1_valid;
    logic [15:0] r_s1_word;
    logic [2:0]  r_s1_fmt;
    logic        r_s1_req;
    logic        r_s2_valid;
    t_desc       r_s2_desc;
    t_desc       n_s2_desc;
    logic        w_s2_load;
    logic        w_s1_load;

    assign w_s2_load = r_s1_valid & (~r_s2_valid | i_ready);
    assign o_ready   = ~r_s1_valid | w_s2_load;
    assign w_s1_load = i_valid & o_ready;

    bst_decode u_decode (
        .i_blend_mode_word    (r_s1_word),
        .i_efb_format         (r_s1_fmt),
        .i_dual_source_request(r_s1_req),
        .o_desc               (n_s2_desc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (~r_s2_valid | i_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_word <= i_blend_mode_word;
            r_s1_fmt  <= i_efb_format;
            r_s1_req  <= i_dual_source_request;
        end
        if (w_s2_load) begin
            r_s2_desc <= n_s2_desc;
        end
    end

    assign o_valid              = r_s2_valid;
    assign o_blend_en           = r_s2_desc.blend_en;
    assign o_logic_op_en        = r_s2_desc.lop_en;
    assign o_logic_op_code      = r_s2_desc.logic_op_code;
    assign o_src_color_factor   = r_s2_desc.src_color_factor;
    assign o_dst_color_factor   = r_s2_desc.dst_color_factor;
    assign o_src_alpha_factor   = r_s2_desc.src_alpha_factor;
    assign o_dst_alpha_factor   = r_s2_desc.dst_alpha_factor;
    assign o_color_combine_mode = r_s2_desc.color_combine_mode;
    assign o_alpha_combine_mode = r_s2_desc.alpha_combine_mode;
    assign o_color_write        = r_s2_desc.color_write;
    assign o_alpha_write        = r_s2_desc.alpha_write;
    assign o_dual_src_alpha     = r_s2_desc.dual_src;

    // A result is never dropped while the consumer stalls.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_logic_op_code))
        else $error("result dropped or changed while stalled");

    a_logic_op_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_logic_op_en |-> !o_blend_en)
        else $error("logic op enabled together with blending");

    a_rop_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_logic_op_code != 8'h00) |-> o_logic_op_en)
        else $error("ROP code set without logic op");

    a_dual_needs_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dual_src_alpha |-> o_alpha_write)
        else $error("dual source without alpha write");

endmodule

[hdl/bst_decode.sv]
`timescale 1ns / 1ps

module bst_decode (
    input  logic [15:0]   i_blend_mode_word,
    input  logic [2:0]    i_efb_format,
    input  logic          i_dual_source_request,
    output bst_pkg::t_desc o_desc
);
    import bst_pkg::*;

    logic       w_blend_en;
    logic       w_logic_bit;
    logic       w_subtract;
    logic [2:0] w_dst_idx;
    logic [2:0] w_src_idx;
    logic [2:0] w_sai;
    logic [2:0] w_dai;
    logic       w_has_color;
    logic       w_has_alpha;
    logic       w_cw;
    logic       w_aw;
    logic       w_dual;
    t_factor    w_sc, w_dc, w_sa, w_da;
    t_factor    w_sc2, w_dc2;

    assign w_blend_en  = i_blend_mode_word[0];
    assign w_logic_bit = i_blend_mode_word[1];
    assign w_subtract  = i_blend_mode_word[11];
    assign w_dst_idx   = i_blend_mode_word[7:5];
    assign w_src_idx   = i_blend_mode_word[10:8];

    assign w_has_color = (i_efb_format != FMT_DEPTH_ONLY);
    assign w_has_alpha = (i_efb_format == FMT_WITH_ALPHA);
    assign w_cw        = i_blend_mode_word[3] & w_has_color;
    assign w_aw        = i_blend_mode_word[4] & w_has_alpha;
    assign w_dual      = i_dual_source_request & w_aw;

    // The alpha terms swap each color term for its alpha counterpart.
    assign w_sai = (w_src_idx == 3'd2 || w_src_idx == 3'd3) ? {1'b1, w_src_idx[1:0]}
                                                           : w_src_idx;
    assign w_dai = (w_dst_idx == 3'd2 || w_dst_idx == 3'd3) ? {2'b10, w_dst_idx[0]}
                                                           : w_dst_idx;

    always_comb begin
        w_sc = F_ONE;
        w_sa = F_ONE;
        w_dc = F_ZERO;
        w_da = F_ZERO;
        o_desc = '0;
        o_desc.color_combine_mode = COMBINE_ADD;
        o_desc.alpha_combine_mode = COMBINE_ADD;
        if (w_blend_en) begin
            if (w_subtract) begin
                w_sc = F_ONE;
                w_sa = F_ONE;
                w_dc = F_ONE;
                w_da = F_ONE;
                o_desc.color_combine_mode = COMBINE_REVSUB;
                o_desc.alpha_combine_mode = COMBINE_REVSUB;
            end else begin
                w_sc = src_map(w_src_idx);
                w_dc = dst_map(w_dst_idx);
                w_sa = src_map(w_sai);
                w_da = dst_map(w_dai);
            end
        end else if (w_logic_bit) begin
            o_desc.lop_en        = 1'b1;
            o_desc.logic_op_code = rop3_map(i_blend_mode_word[15:12]);
        end

        w_sc2 = w_has_alpha ? w_sc : no_alpha_fix(w_sc);
        w_dc2 = w_has_alpha ? w_dc : no_alpha_fix(w_dc);

        o_desc.blend_en          = w_blend_en;
        o_desc.src_color_factor  = w_dual ? dual_fix(w_sc2) : w_sc2;
        o_desc.dst_color_factor  = w_dual ? dual_fix(w_dc2) : w_dc2;
        o_desc.src_alpha_factor  = w_dual ? dual_fix(w_sa) : w_sa;
        o_desc.dst_alpha_factor  = w_dual ? dual_fix(w_da) : w_da;
        o_desc.color_write       = w_cw;
        o_desc.alpha_write       = w_aw;
        o_desc.dual_src          = w_dual;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bst_pkg::*;

    localparam int RANDOM_WORDS   = 750;
    localparam int IDLE_PERCENT   = 29;
    localparam int CALM_FIRST     = 300;
    localparam int CALM_LAST      = 450;
    localparam int HOLD_OFF_AT    = 150;
    localparam int HOLD_OFF_LEN   = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct {
        logic [15:0] word;
        logic [2:0]  fmt;
        logic        dsr;
        bit          pause;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_blend_mode_word;
    logic [2:0]  i_efb_format;
    logic        i_dual_source_request;
    logic        o_valid;
    logic        i_ready;
    logic        o_blend_en;
    logic        o_logic_op_en;
    logic [7:0]  o_logic_op_code;
    logic [3:0]  o_src_color_factor;
    logic [3:0]  o_dst_color_factor;
    logic [3:0]  o_src_alpha_factor;
    logic [3:0]  o_dst_alpha_factor;
    logic        o_color_combine_mode;
    logic        o_alpha_combine_mode;
    logic        o_color_write;
    logic        o_alpha_write;
    logic        o_dual_src_alpha;

    t_req  req_q[$];
    t_desc descriptor_q[$];
    t_req  cur_req;
    t_desc got;
    t_desc want;
    int    total_count = 0;
    int    sent_count = 0;
    int    recv_count = 0;
    int    error_count = 0;
    int    hold_off_left = 0;
    bit    hold_off_done = 0;
    int    quiet_cycles = 0;
    bit    offer;

    blend_state_translator_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_blend_mode_word     (i_blend_mode_word),
        .i_efb_format          (i_efb_format),
        .i_dual_source_request (i_dual_source_request),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_blend_en            (o_blend_en),
        .o_logic_op_en         (o_logic_op_en),
        .o_logic_op_code       (o_logic_op_code),
        .o_src_color_factor    (o_src_color_factor),
        .o_dst_color_factor    (o_dst_color_factor),
        .o_src_alpha_factor    (o_src_alpha_factor),
        .o_dst_alpha_factor    (o_dst_alpha_factor),
        .o_color_combine_mode  (o_color_combine_mode),
        .o_alpha_combine_mode  (o_alpha_combine_mode),
        .o_color_write         (o_color_write),
        .o_alpha_write         (o_alpha_write),
        .o_dual_src_alpha      (o_dual_src_alpha)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Source index table: indexes 2 and 3 select destination color, the rest map
    // straight onto the factor code.
    function automatic t_factor src_index_factor(input logic [2:0] idx);
        if (idx == 3'd2) return F_DSTCOL;
        if (idx == 3'd3) return F_INVDSTCOL;
        return t_factor'({1'b0, idx});
    endfunction

    function automatic t_factor drop_dst_alpha(input t_factor f);
        case (f)
            F_DSTA:    return F_ONE;
            F_INVDSTA: return F_ZERO;
            default:   return f;
        endcase
    endfunction

    function automatic t_factor to_second_source(input t_factor f);
        case (f)
            F_SRCA:    return F_SRC1A;
            F_INVSRCA: return F_INVSRC1A;
            default:   return f;
        endcase
    endfunction

    function automatic t_desc predict_descriptor(input t_req r);
        t_desc      d;
        logic [2:0] s_idx;
        logic [2:0] d_idx;
        logic [3:0] rop_nibble;
        logic       alpha_fmt;
        s_idx = r.word[10:8];
        d_idx = r.word[7:5];
        alpha_fmt = (r.fmt == FMT_WITH_ALPHA);
        d = '0;
        d.blend_en = r.word[0];
        d.color_write = r.word[3] && (r.fmt != FMT_DEPTH_ONLY);
        d.alpha_write = r.word[4] && alpha_fmt;
        d.dual_src = r.dsr && d.alpha_write;
        d.src_color_factor = F_ONE;
        d.src_alpha_factor = F_ONE;
        d.dst_color_factor = F_ZERO;
        d.dst_alpha_factor = F_ZERO;
        d.color_combine_mode = COMBINE_ADD;
        d.alpha_combine_mode = COMBINE_ADD;
        if (r.word[0]) begin
            if (r.word[11]) begin
                d.src_color_factor = F_ONE;
                d.src_alpha_factor = F_ONE;
                d.dst_color_factor = F_ONE;
                d.dst_alpha_factor = F_ONE;
                d.color_combine_mode = COMBINE_REVSUB;
                d.alpha_combine_mode = COMBINE_REVSUB;
            end else begin
                d.src_color_factor = src_index_factor(s_idx);
                // The destination table is the identity on the factor codes.
                d.dst_color_factor = t_factor'({1'b0, d_idx});
                // For alpha, a color term turns into the alpha term of the same side.
                if (s_idx == 3'd2) d.src_alpha_factor = F_DSTA;
                else if (s_idx == 3'd3) d.src_alpha_factor = F_INVDSTA;
                else d.src_alpha_factor = src_index_factor(s_idx);
                if (d_idx == 3'd2) d.dst_alpha_factor = F_SRCA;
                else if (d_idx == 3'd3) d.dst_alpha_factor = F_INVSRCA;
                else d.dst_alpha_factor = t_factor'({1'b0, d_idx});
            end
        end else if (r.word[1]) begin
            // Each nibble of the ROP3 code is the op index with its bits reversed.
            rop_nibble = {r.word[12], r.word[13], r.word[14], r.word[15]};
            d.lop_en = 1'b1;
            d.logic_op_code = {rop_nibble, rop_nibble};
        end
        if (!alpha_fmt) begin
            d.src_color_factor = drop_dst_alpha(d.src_color_factor);
            d.dst_color_factor = drop_dst_alpha(d.dst_color_factor);
        end
        if (d.dual_src) begin
            d.src_color_factor = to_second_source(d.src_color_factor);
            d.dst_color_factor = to_second_source(d.dst_color_factor);
            d.src_alpha_factor = to_second_source(d.src_alpha_factor);
            d.dst_alpha_factor = to_second_source(d.dst_alpha_factor);
        end
        return d;
    endfunction

    task automatic add_req(input logic [15:0] word, input logic [2:0] fmt, input logic dsr,
                           input bit pause);
        t_req r;
        r.word = word;
        r.fmt = fmt;
        r.dsr = dsr;
        r.pause = pause;
        req_q.push_back(r);
        total_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                descriptor_q.push_back(predict_descriptor(cur_req));
                sent_count++;
            end
            if (!i_valid || o_ready) begin
                offer = 1'b0;
                if (req_q.size() != 0) begin
                    if (req_q[0].pause && descriptor_q.size() != 0) begin
                        offer = 1'b0;
                    end else if ((sent_count < CALM_FIRST || sent_count >= CALM_LAST)
                                 && $urandom_range(0, 99) < IDLE_PERCENT) begin
                        offer = 1'b0;
                    end else begin
                        offer = 1'b1;
                    end
                end
                if (offer) begin
                    cur_req = req_q.pop_front();
                    i_blend_mode_word <= cur_req.word;
                    i_efb_format <= cur_req.fmt;
                    i_dual_source_request <= cur_req.dsr;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                recv_count++;
                got.blend_en = o_blend_en;
                got.lop_en = o_logic_op_en;
                got.logic_op_code = o_logic_op_code;
                got.src_color_factor = o_src_color_factor;
                got.dst_color_factor = o_dst_color_factor;
                got.src_alpha_factor = o_src_alpha_factor;
                got.dst_alpha_factor = o_dst_alpha_factor;
                got.color_combine_mode = o_color_combine_mode;
                got.alpha_combine_mode = o_alpha_combine_mode;
                got.color_write = o_color_write;
                got.alpha_write = o_alpha_write;
                got.dual_src = o_dual_src_alpha;
                if (descriptor_q.size() == 0) begin
                    $error("descriptor received with none outstanding");
                    error_count++;
                end else begin
                    want = descriptor_q.pop_front();
                    check_field("blend_en", 8'(want.blend_en), 8'(got.blend_en));
                    check_field("logic_op_en", 8'(want.lop_en), 8'(got.lop_en));
                    check_field("logic_op_code", want.logic_op_code, got.logic_op_code);
                    check_field("src_color_factor", 8'(want.src_color_factor),
                                8'(got.src_color_factor));
                    check_field("dst_color_factor", 8'(want.dst_color_factor),
                                8'(got.dst_color_factor));
                    check_field("src_alpha_factor", 8'(want.src_alpha_factor),
                                8'(got.src_alpha_factor));
                    check_field("dst_alpha_factor", 8'(want.dst_alpha_factor),
                                8'(got.dst_alpha_factor));
                    check_field("color_combine_mode", 8'(want.color_combine_mode),
                                8'(got.color_combine_mode));
                    check_field("alpha_combine_mode", 8'(want.alpha_combine_mode),
                                8'(got.alpha_combine_mode));
                    check_field("color_write", 8'(want.color_write), 8'(got.color_write));
                    check_field("alpha_write", 8'(want.alpha_write), 8'(got.alpha_write));
                    check_field("dual_src_alpha", 8'(want.dual_src), 8'(got.dual_src));
                end
            end
            // One long hold-off lets the block fill up and push back on the sender.
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_ready <= 1'b0;
            end else if (!hold_off_done && recv_count == HOLD_OFF_AT) begin
                hold_off_done = 1'b1;
                hold_off_left = HOLD_OFF_LEN - 1;
                i_ready <= 1'b0;
            end else if (recv_count >= CALM_FIRST && recv_count < CALM_LAST) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] w;
        logic [2:0]  fmt;
        int          roll;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_blend_mode_word = '0;
        i_efb_format = '0;
        i_dual_source_request = 1'b0;

        // Directed words: field extremes, every factor index, logic ops and formats.
        add_req(16'h0000, 3'd0, 1'b0, 1'b0);
        add_req(16'hFFFF, FMT_WITH_ALPHA, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++) begin
            w = 16'h0019 | (16'(i) << 8) | (16'(7 - i) << 5);
            add_req(w, FMT_WITH_ALPHA, i[0], 1'b0);
        end
        add_req(16'h06F9, 3'd0, 1'b1, 1'b0);
        add_req(16'h07D9, 3'd2, 1'b0, 1'b0);
        add_req(16'h04B9, FMT_DEPTH_ONLY, 1'b1, 1'b0);
        add_req(16'hF01A, 3'd7, 1'b0, 1'b0);
        add_req(16'h0002, 3'd2, 1'b0, 1'b0);
        add_req(16'h5006, FMT_WITH_ALPHA, 1'b1, 1'b0);
        add_req(16'hA002, 3'd4, 1'b0, 1'b0);
        add_req(16'h0800, 3'd5, 1'b1, 1'b0);
        add_req(16'h7703, 3'd6, 1'b1, 1'b0);
        add_req(16'hFFFF, 3'd0, 1'b1, 1'b0);
        add_req(16'h0819, FMT_DEPTH_ONLY, 1'b1, 1'b0);
        add_req(16'h049B, FMT_WITH_ALPHA, 1'b1, 1'b0);

        // Mostly well-formed blend or logic-op words with random content, rest raw.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            w = 16'($urandom_range(0, 65535));
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                w[0] = 1'b1;
                w[11] = ($urandom_range(0, 9) == 0);
            end else if (roll < 85) begin
                w[0] = 1'b0;
                w[1] = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) fmt = FMT_WITH_ALPHA;
            else if (roll < 60) fmt = FMT_DEPTH_ONLY;
            else fmt = 3'($urandom_range(0, 7));
            add_req(w, fmt, 1'($urandom_range(0, 1)), (i == 0 || i == RANDOM_WORDS / 2));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count != total_count || descriptor_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
